@@ rtl/core/rpg_pkg.sv @@
package rpg_pkg;

	localparam int COORD_BITS = 12;
	localparam int EXT_W      = COORD_BITS + 1;
	localparam int THR_W      = 13;
	localparam int SQ_W       = 2 * THR_W;

	localparam logic [THR_W-1:0] THR_RESET  = THR_W'(100);
	localparam logic [EXT_W-1:0] EXTENT_MAX = EXT_W'(1) << COORD_BITS;

	typedef struct packed {
		logic [COORD_BITS-1:0] rect_x;
		logic [COORD_BITS-1:0] rect_y;
		logic [EXT_W-1:0]      rect_width;
		logic [EXT_W-1:0]      rect_height;
		logic                  last_rect;
	} rect_in_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] group_x;
		logic [COORD_BITS-1:0] group_y;
		logic [EXT_W-1:0]      group_width;
		logic [EXT_W-1:0]      group_height;
		logic                  last_group;
		logic                  table_overflow;
	} group_out_t;

	// One table entry: corner and extent of a group.
	typedef struct packed {
		logic [COORD_BITS-1:0] left;
		logic [COORD_BITS-1:0] top;
		logic [EXT_W-1:0]      w;
		logic [EXT_W-1:0]      h;
	} grp_t;

	typedef enum logic [1:0] {
		DOP_NONE,
		DOP_LIMIT,
		DOP_SQX,
		DOP_SQY
	} dist_op_t;

	typedef struct packed {
		dist_op_t          op;
		logic [THR_W-1:0]  operand;
	} dist_ctrl_t;

endpackage

@@ rtl/core/rpg_table.sv @@
module rpg_table import rpg_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  grp_t             wdata,
	input  logic [IDX_W-1:0] raddr,
	output grp_t             rdata
);

	grp_t mem [DEPTH];
	grp_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/rpg_dist_unit.sv @@
module rpg_dist_unit import rpg_pkg::*; (
	input  logic       clk,
	input  dist_ctrl_t ctrl,
	output logic       hit
);

	logic [SQ_W-1:0] prod;
	logic [SQ_W-1:0] limit_q;
	logic [SQ_W-1:0] sq_q;
	logic [SQ_W-1:0] acc_q;
	logic [SQ_W:0]   sum;

	// Shared squarer: threshold, then dx, then dy.
	assign prod = ctrl.operand * ctrl.operand;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			DOP_LIMIT: limit_q <= prod;
			DOP_SQX:   sq_q    <= prod;
			DOP_SQY: begin
				sq_q  <= prod;
				acc_q <= sq_q;
			end
			default: ;
		endcase
	end

	assign sum = {1'b0, acc_q} + {1'b0, sq_q};
	assign hit = sum < {1'b0, limit_q};

endmodule

@@ rtl/core/rpg_merge.sv @@
module rpg_merge import rpg_pkg::*; (
	input  grp_t grp,
	input  grp_t rect,
	output grp_t merged
);

	// Returns {start, saturated span} of the union on one axis.
	function automatic logic [COORD_BITS+EXT_W-1:0] merge_axis(
		input logic [COORD_BITS-1:0] glo,
		input logic [EXT_W-1:0]      gext,
		input logic [COORD_BITS-1:0] lo,
		input logic [EXT_W-1:0]      ext
	);
		logic [EXT_W-1:0]      gend;
		logic [EXT_W-1:0]      nend;
		logic [COORD_BITS-1:0] start;
		logic [EXT_W-1:0]      stop;
		logic [EXT_W-1:0]      span;
		gend  = {1'b0, glo} + gext;
		nend  = {1'b0, lo} + ext;
		start = (glo < lo) ? glo : lo;
		stop  = (gend > nend) ? gend : nend;
		span  = stop - {1'b0, start};
		if (span > EXTENT_MAX) begin
			span = EXTENT_MAX;
		end
		return {start, span};
	endfunction

	always_comb begin
		{merged.left, merged.w} = merge_axis(grp.left, grp.w, rect.left, rect.w);
		{merged.top,  merged.h} = merge_axis(grp.top,  grp.h, rect.top,  rect.h);
	end

endmodule

@@ rtl/core/rectangle_proximity_grouper_unit.sv @@
// Per rectangle: LIMIT, then SQX, SQY, TEST per group compared before a join or an append
// (FETCH before all but the first), then MERGE or APPEND; an empty table goes from LIMIT
// to APPEND. A last rectangle emits each group (EFETCH, ESEND), plus any output stall.
// Throughput: one rectangle per busy period, set by the single shared squarer and the
// table's single read port. Reset: async active low; clears group count, overflow flag,
// sequencer and output valid, threshold returns to 100. Table contents are not cleared.
module rectangle_proximity_grouper_unit import rpg_pkg::*; #(
	parameter int MAX_GROUPS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rect_in_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output group_out_t       out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [THR_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_GROUPS + 1);
	localparam int IDX_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_GROUPS);

	// Sequencer: LIMIT squares the threshold; each group then goes FETCH (table read;
	// skipped for entry 0), SQX, SQY (shared squarer), TEST (sum vs limit).
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LIMIT,
		ST_FETCH,
		ST_SQX,
		ST_SQY,
		ST_TEST,
		ST_MERGE,
		ST_APPEND,
		ST_EFETCH,
		ST_ESEND
	} state_t;

	state_t           state_q;
	logic [THR_W-1:0] thr_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] idx_nxt;
	logic             ovf_q;
	logic             out_valid_q;
	group_out_t       out_q;
	grp_t             rect_q;
	logic             last_q;

	grp_t             rd;
	grp_t             merged;
	grp_t             tbl_wdata;
	logic             tbl_we;
	logic [IDX_W-1:0] tbl_waddr;
	dist_ctrl_t       dctl;
	logic             hit;
	logic [COORD_BITS-1:0] dx;
	logic [COORD_BITS-1:0] dy;
	logic [EXT_W-1:0] w_clamped;
	logic [EXT_W-1:0] h_clamped;
	logic             out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign idx_nxt   = idx_q + CNT_W'(1);

	// Zero extent reads as 1, oversize extent saturates.
	always_comb begin
		w_clamped = in_data.rect_width;
		h_clamped = in_data.rect_height;
		if (w_clamped == '0) w_clamped = EXT_W'(1);
		else if (w_clamped > EXTENT_MAX) w_clamped = EXTENT_MAX;
		if (h_clamped == '0) h_clamped = EXT_W'(1);
		else if (h_clamped > EXTENT_MAX) h_clamped = EXTENT_MAX;
	end

	// Corner differences against the entry being compared.
	assign dx = (rect_q.left > rd.left) ? rect_q.left - rd.left : rd.left - rect_q.left;
	assign dy = (rect_q.top  > rd.top)  ? rect_q.top  - rd.top  : rd.top  - rect_q.top;

	always_comb begin
		case (state_q)
			ST_LIMIT: dctl = '{op: DOP_LIMIT, operand: thr_q};
			ST_SQX:   dctl = '{op: DOP_SQX,   operand: THR_W'(dx)};
			ST_SQY:   dctl = '{op: DOP_SQY,   operand: THR_W'(dy)};
			default:  dctl = '{op: DOP_NONE,  operand: thr_q};
		endcase
	end

	// Table write: merge in place, or append at the end when there is room.
	assign tbl_we    = (state_q == ST_MERGE) ||
	                   ((state_q == ST_APPEND) && (count_q != CNT_FULL));
	assign tbl_waddr = (state_q == ST_MERGE) ? idx_q[IDX_W-1:0] : count_q[IDX_W-1:0];
	assign tbl_wdata = (state_q == ST_MERGE) ? merged : rect_q;

	// Emit a group when the output register is free or being drained.
	assign out_load  = (state_q == ST_ESEND) && (!out_valid_q || out_ready);

	rpg_table #(
		.DEPTH (MAX_GROUPS),
		.IDX_W (IDX_W)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rd)
	);

	rpg_dist_unit u_dist (
		.clk  (clk),
		.ctrl (dctl),
		.hit  (hit)
	);

	rpg_merge u_merge (
		.grp    (rd),
		.rect   (rect_q),
		.merged (merged)
	);

	// Hold the incoming rectangle for the whole scan.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rect_q <= '{left: in_data.rect_x, top: in_data.rect_y,
			            w: w_clamped, h: h_clamped};
			last_q <= in_data.last_rect;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= THR_RESET;
			count_q     <= '0;
			idx_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end

			// Drop the valid once the request is taken and nothing replaces it.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q   <= '0;
						state_q <= ST_LIMIT;
					end
				end
				// Table read of entry 0 overlaps the threshold square.
				ST_LIMIT: begin
					state_q <= (count_q == '0) ? ST_APPEND : ST_SQX;
				end
				ST_FETCH: state_q <= ST_SQX;
				ST_SQX:   state_q <= ST_SQY;
				ST_SQY:   state_q <= ST_TEST;
				// First close group wins; otherwise advance or open a new group.
				ST_TEST: begin
					if (hit) begin
						state_q <= ST_MERGE;
					end else if (idx_nxt == count_q) begin
						state_q <= ST_APPEND;
					end else begin
						idx_q   <= idx_nxt;
						state_q <= ST_FETCH;
					end
				end
				ST_MERGE, ST_APPEND: begin
					if ((state_q == ST_APPEND) && (count_q != CNT_FULL)) begin
						count_q <= count_q + CNT_W'(1);
					end else if (state_q == ST_APPEND) begin
						ovf_q <= 1'b1;
					end
					idx_q   <= '0;
					state_q <= last_q ? ST_EFETCH : ST_IDLE;
				end
				ST_EFETCH: state_q <= ST_ESEND;
				ST_ESEND: begin
					if (out_load) begin
						out_q <= '{group_x:        rd.left,
						           group_y:        rd.top,
						           group_width:    rd.w,
						           group_height:   rd.h,
						           last_group:     (idx_nxt == count_q),
						           table_overflow: ovf_q};
						if (idx_nxt == count_q) begin
							// Run complete: reset the group count, emptying the table, and clear the flag.
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_nxt;
							state_q <= ST_EFETCH;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/rpg_checker.sv @@
module rpg_checker import rpg_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input group_out_t out_data
);

	// A stalled result request holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// An accepted rectangle keeps the block busy, with in_ready low, once it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input accepted during scan");

	// While a group other than the final one is offered, no rectangle is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_group |-> !in_ready)
		else $error("input accepted during group output");

endmodule

bind rectangle_proximity_grouper_unit rpg_checker u_rpg_checker (.*);
